[hw/rtl/lirf_pkg.sv]
package lirf_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int PHASE_STEP_W = 20;
   localparam int FRAME_LEN_W  = 9;
   localparam int CSR_INDEX_W  = 1;
   localparam int MAX_RUN      = 16;
   localparam int RUN_W        = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 1'b1;

   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET   = 20'd98304;
   localparam logic [FRAME_LEN_W-1:0]  FRAME_LENGTH_RESET = 9'd200;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic skip;
      logic mul;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic acc_below_one;
      logic run_last;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/lirf_ctrl.sv]
module lirf_ctrl
   import lirf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.acc_below_one) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.run_last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = status.acc_below_one;
               cmd.skip = !status.acc_below_one;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/lirf_dp.sv]
module lirf_dp
   import lirf_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 16,
   parameter int MAX_FRAME       = 256
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic [PHASE_STEP_W-1:0]        phase_step,
   input  logic [FRAME_LEN_W-1:0]         frame_length,
   input  logic signed [SAMPLE_W-1:0]     req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_W-1:0]     rsp_sample_out,
   output logic                           rsp_frame_end,
   output logic                           rsp_run_last
);

   localparam int F      = PHASE_FRAC_BITS;
   localparam int ACC_W  = ((F > PHASE_STEP_W) ? F : PHASE_STEP_W) + 2;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + F + 1;
   localparam int TOT_W  = PROD_W + 1;
   localparam int INT_W  = TOT_W - F;
   localparam int CNT_W  = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int LEN_W  = ((CNT_W + 1) > FRAME_LEN_W) ? (CNT_W + 1) : FRAME_LEN_W;

   localparam logic [ACC_W-1:0] PHASE_ONE = ACC_W'(1) << F;
   localparam logic [ACC_W-1:0] MIN_STEP  = PHASE_ONE >> 4;
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);

   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]    prev_ff, prev_in;
   logic                          primed_ff, primed_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [RUN_W-1:0]              run_ff, run_in;
   logic signed [SAMPLE_W-1:0]    cur_ff, cur_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic                          fend_ff, fend_in;
   logic                          last_ff, last_in;

   logic [ACC_W-1:0]              step_eff;
   logic [ACC_W-1:0]              acc_sum;
   logic [ACC_W-1:0]              acc_wrap;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [TOT_W-1:0]       total;
   logic signed [INT_W-1:0]       s_floor;
   logic signed [INT_W-1:0]       s_trunc;
   logic signed [SAMPLE_W-1:0]    s_sat;
   logic signed [SAMPLE_W-1:0]    s_out;
   logic [LEN_W-1:0]              len_eff;
   logic [LEN_W-1:0]              cnt_inc;
   logic                          frame_done;
   logic                          run_done;

   always_comb begin
      step_eff = (ACC_W'(phase_step) < MIN_STEP) ? MIN_STEP : ACC_W'(phase_step);
      acc_sum  = acc_ff + step_eff;
      acc_wrap = (acc_sum >= PHASE_ONE) ? (acc_sum - PHASE_ONE) : '0;
      run_done = (acc_sum >= PHASE_ONE) || (run_ff == RUN_W'(MAX_RUN - 1));

      diff = DIFF_W'(cur_ff) - DIFF_W'(prev_ff);
      total = (TOT_W'(prev_ff) <<< F) + TOT_W'(prod_ff);
      s_floor = INT_W'(total >>> F);
      s_trunc = s_floor + INT_W'(total[TOT_W-1] && (total[F-1:0] != '0));
      priority if (s_trunc > INT_W'(SAMPLE_MAX)) begin
         s_sat = SAMPLE_MAX;
      end else if (s_trunc < INT_W'(SAMPLE_MIN)) begin
         s_sat = SAMPLE_MIN;
      end else begin
         s_sat = SAMPLE_W'(s_trunc);
      end
      s_out = primed_ff ? s_sat : cur_ff;

      priority if (frame_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (LEN_W'(frame_length) > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = LEN_W'(frame_length);
      end
      cnt_inc    = LEN_W'(cnt_ff) + LEN_W'(1);
      frame_done = cnt_inc >= len_eff;
   end

   always_comb begin
      acc_in    = acc_ff;
      prev_in   = prev_ff;
      primed_in = primed_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      cur_in    = cur_ff;
      prod_in   = prod_ff;
      sample_in = sample_ff;
      fend_in   = fend_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;

      if (cmd.load) begin
         cur_in = req_sample_in;
         run_in = '0;
      end
      if (cmd.skip) begin
         acc_in    = acc_ff - PHASE_ONE;
         prev_in   = req_sample_in;
         primed_in = 1'b1;
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(diff) * PROD_W'($signed({1'b0, acc_ff[F-1:0]}));
      end
      if (cmd.emit) begin
         valid_in  = 1'b1;
         sample_in = s_out;
         fend_in   = frame_done;
         last_in   = run_done;
         cnt_in    = frame_done ? '0 : cnt_inc[CNT_W-1:0];
         run_in    = run_ff + RUN_W'(1);
         if (run_done) begin
            acc_in    = acc_wrap;
            prev_in   = cur_ff;
            primed_in = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         prev_ff   <= '0;
         primed_ff <= 1'b0;
         cnt_ff    <= '0;
         run_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         prev_ff   <= prev_in;
         primed_ff <= primed_in;
         cnt_ff    <= cnt_in;
         run_ff    <= run_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
      fend_ff   <= fend_in;
      last_ff   <= last_in;
   end

   assign status.acc_below_one = acc_ff < PHASE_ONE;
   assign status.run_last      = run_done;
   assign status.out_free      = !valid_ff || !rsp_stall;

   assign rsp_valid      = valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_frame_end  = fend_ff;
   assign rsp_run_last   = last_ff;

endmodule

[hw/rtl/linear_interp_resampler_framer_core.sv]
// a request is taken in the idle state; each result of it then has its product registered
// in the multiply state by the one shared multiplier and enters the output register in the
// emit state once that register is free; a request making no result ends in idle. No new
// request is taken until a run ends; results stay in the output register while it is taken
// synchronous active-high reset: phase, history, frame count cleared, registers to defaults
module linear_interp_resampler_framer_core
   import lirf_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 16,
   parameter int MAX_FRAME       = 256
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_frame_end,
   output logic                        rsp_run_last,
   input  logic                        csr_write,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [PHASE_STEP_W-1:0]     csr_wdata
);

   logic [PHASE_STEP_W-1:0] phase_step_ff, phase_step_in;
   logic [FRAME_LEN_W-1:0]  frame_length_ff, frame_length_in;
   cmd_type                 cmd;
   status_type              status;

   always_comb begin
      phase_step_in   = phase_step_ff;
      frame_length_in = frame_length_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   phase_step_in   = csr_wdata;
            CSR_FRAME_LENGTH: frame_length_in = csr_wdata[FRAME_LEN_W-1:0];
            default: begin
               phase_step_in = phase_step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PHASE_STEP_RESET;
         frame_length_ff <= FRAME_LENGTH_RESET;
      end else begin
         phase_step_ff   <= phase_step_in;
         frame_length_ff <= frame_length_in;
      end
   end

   lirf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lirf_dp #(
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
      .MAX_FRAME       (MAX_FRAME)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .phase_step     (phase_step_ff),
      .frame_length   (frame_length_ff),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

import lirf_pkg::*;

typedef struct {
   logic signed [SAMPLE_W-1:0] sample;
   logic                       frame_end;
   logic                       run_last;
} resample_out_type;

class resample_scoreboard #(int FRAC_BITS = 16, int FRAME_MAX = 256);
   localparam longint PHASE_ONE = longint'(1) << FRAC_BITS;
   localparam longint MIN_STEP  = PHASE_ONE >> 4;

   logic [PHASE_STEP_W-1:0]    step_reg;
   logic [FRAME_LEN_W-1:0]     flen_reg;
   longint                     phase;
   logic signed [SAMPLE_W-1:0] prev;
   bit                         primed;
   int unsigned                fcount;
   resample_out_type           results_q[$];
   int                         mismatches;
   int                         checked;
   int                         accepted;
   int                         writes;
   int                         frames_seen;

   function new();
      step_reg    = PHASE_STEP_RESET;
      flen_reg    = FRAME_LENGTH_RESET;
      phase       = 0;
      prev        = '0;
      primed      = 0;
      fcount      = 0;
      mismatches  = 0;
      checked     = 0;
      accepted    = 0;
      writes      = 0;
      frames_seen = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [PHASE_STEP_W-1:0] v);
      if (idx == CSR_PHASE_STEP) begin
         step_reg = v;
      end else if (idx == CSR_FRAME_LENGTH) begin
         flen_reg = v[FRAME_LEN_W-1:0];
      end
      writes++;
   endfunction

   // interpolated run caused by one request
   function void note_request(logic signed [SAMPLE_W-1:0] cur);
      longint           step;
      int unsigned      flen;
      int               n;
      longint           total;
      longint           q;
      resample_out_type r;
      step = (longint'(step_reg) < MIN_STEP) ? MIN_STEP : longint'(step_reg);
      if (flen_reg == 0) begin
         flen = 1;
      end else if (flen_reg > FRAME_MAX) begin
         flen = FRAME_MAX;
      end else begin
         flen = 32'(flen_reg);
      end
      n = 0;
      while (phase < PHASE_ONE && n < MAX_RUN) begin
         if (primed) begin
            total = longint'(prev) * PHASE_ONE + (longint'(cur) - longint'(prev)) * phase;
            q = total / PHASE_ONE;
            if (q > SAMPLE_MAX) begin
               q = SAMPLE_MAX;
            end else if (q < SAMPLE_MIN) begin
               q = SAMPLE_MIN;
            end
            r.sample = q[SAMPLE_W-1:0];
         end else begin
            r.sample = cur;
         end
         fcount++;
         r.frame_end = 1'b0;
         if (fcount >= flen) begin
            fcount = 0;
            r.frame_end = 1'b1;
         end
         r.run_last = 1'b0;
         results_q.push_back(r);
         n++;
         phase += step;
      end
      if (n > 0) begin
         results_q[results_q.size()-1].run_last = 1'b1;
      end
      phase = (phase >= PHASE_ONE) ? phase - PHASE_ONE : 0;
      prev = cur;
      primed = 1;
      accepted++;
   endfunction

   function void check_result(logic signed [SAMPLE_W-1:0] s, logic fe, logic rl);
      resample_out_type e;
      if (results_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected output: sample %0d frame_end %b run_last %b", s, fe, rl);
         end
         return;
      end
      e = results_q.pop_front();
      checked++;
      if (fe === 1'b1) begin
         frames_seen++;
      end
      if (s !== e.sample || fe !== e.frame_end || rl !== e.run_last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("output %0d: expected sample %0d frame_end %b run_last %b, got %0d %b %b",
                     checked, e.sample, e.frame_end, e.run_last, s, fe, rl);
         end
      end
   endfunction
endclass

module tb;
   localparam int FRAC_BITS = 16;
   localparam int FRAME_MAX = 256;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_frame_end;
   logic                       rsp_run_last;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [PHASE_STEP_W-1:0]    csr_wdata = '0;

   int send_idle = 35;
   int recv_idle = 55;

   resample_scoreboard #(FRAC_BITS, FRAME_MAX) sb;

   linear_interp_resampler_framer_core #(
      .PHASE_FRAC_BITS(FRAC_BITS),
      .MAX_FRAME(FRAME_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_frame_end(rsp_frame_end),
      .rsp_run_last(rsp_run_last),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_result(rsp_sample_out, rsp_frame_end, rsp_run_last);
      end
   end

   task automatic send_sample(logic signed [SAMPLE_W-1:0] v);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= v;
      do @(posedge clock); while (req_stall);
      sb.note_request(v);
   endtask

   task automatic configure(logic [PHASE_STEP_W-1:0] step, logic [FRAME_LEN_W-1:0] flen);
      while (sb.results_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      @(posedge clock);
      sb.write_reg(CSR_PHASE_STEP, step);
      csr_index <= CSR_FRAME_LENGTH;
      csr_wdata <= PHASE_STEP_W'(flen);
      @(posedge clock);
      sb.write_reg(CSR_FRAME_LENGTH, PHASE_STEP_W'(flen));
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: pick_sample = SAMPLE_MAX;
         1: pick_sample = SAMPLE_MIN;
         2: pick_sample = SAMPLE_W'($urandom_range(64) - 32);
         default: pick_sample = SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [PHASE_STEP_W-1:0] pick_step();
      case ($urandom_range(9))
         0: pick_step = PHASE_STEP_W'($urandom_range(4095));
         1: pick_step = 20'd4096;
         2, 3, 4: pick_step = PHASE_STEP_W'($urandom_range(140000, 40000));
         5: pick_step = 20'd65536;
         6: pick_step = PHASE_STEP_RESET;
         7: pick_step = PHASE_STEP_W'($urandom_range(40000, 4096));
         8: pick_step = PHASE_STEP_W'($urandom_range(1048575, 140000));
         default: pick_step = 20'hfffff;
      endcase
   endfunction

   function automatic logic [FRAME_LEN_W-1:0] pick_length();
      case ($urandom_range(5))
         0: pick_length = FRAME_LEN_W'($urandom_range(3));
         1: pick_length = FRAME_LEN_W'($urandom_range(16, 1));
         2: pick_length = FRAME_LEN_W'($urandom_range(255, 17));
         3: pick_length = 9'd256;
         4: pick_length = FRAME_LEN_W'($urandom_range(511, 257));
         default: pick_length = FRAME_LENGTH_RESET;
      endcase
   endfunction

   initial begin
      logic signed [SAMPLE_W-1:0] corner_samples[7];
      corner_samples = '{16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0001, 16'sh0001,
                         -16'sh8000};
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, first request passes through unchanged
      foreach (corner_samples[i]) send_sample(corner_samples[i]);
      req_valid <= 1'b0;

      // step below minimum, zero frame length
      configure(20'd0, 9'd0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd12345);
      req_valid <= 1'b0;

      // largest step, frame length above maximum
      configure(20'hfffff, 9'd511);
      repeat (6) send_sample(pick_sample());
      req_valid <= 1'b0;

      // step lowered with phase left high
      configure(20'd4095, 9'd256);
      repeat (6) send_sample(pick_sample());
      req_valid <= 1'b0;

      configure(20'd65536, 9'd1);
      repeat (3) send_sample(pick_sample());
      req_valid <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle = 35;
            recv_idle = 55;
         end else if (p < 4) begin
            send_idle = 55;
            recv_idle = 35;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         configure(pick_step(), pick_length());
         for (int i = 0; i < 75; i++) send_sample(pick_sample());
         req_valid <= 1'b0;
      end

      while (sb.results_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (sb.results_q.size() != 0) begin
         $display("%0d expected outputs never arrived", sb.results_q.size());
      end
      $display("run covered %0d input requests and %0d checked outputs (%0d frame ends)",
               sb.accepted, sb.checked, sb.frames_seen);
      $display("%0d register writes over step and frame length extremes, %0d mismatches",
               sb.writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.results_q.size() == 0) begin
         $display("PASS linear_interp_resampler_framer_core");
      end else begin
         $display("FAIL linear_interp_resampler_framer_core");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL linear_interp_resampler_framer_core");
      $finish;
   end
endmodule
